// ----- sv/cbm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bank mapper.
// No dependencies; every other file uses this package by scoped names.
package cbm_pkg;

   // Field widths
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int KIND_W     = 3;
   localparam int ROM_ADDR_W = 23;
   localparam int RAM_ADDR_W = 17;
   localparam int ROM_BANK_W = 9;
   localparam int RAM_BANK_W = 8;
   localparam int MAPPER_W   = 2;
   localparam int BANKS_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Clock register file
   localparam int RTC_COUNT = 5;
   localparam int RTC_IDX_W = $clog2(RTC_COUNT);
   localparam logic [RAM_BANK_W-1:0] RTC_BASE = 8'd8;

   // Queue between decoder and executor
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAPPER_KIND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_BANKS   = 1'd1;

   // Controller kinds
   localparam logic [MAPPER_W-1:0] MAPPER_MBC1   = 2'd0;
   localparam logic [MAPPER_W-1:0] MAPPER_MBC3   = 2'd1;
   localparam logic [MAPPER_W-1:0] MAPPER_MBC5   = 2'd2;
   localparam logic [MAPPER_W-1:0] MAPPER_UNUSED = 2'd3;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ROM_RD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RAM_RD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RAM_WR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RTC_RD = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REG_WR = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd5;

   // 8 KiB pages of the bus, selected by address[15:13]
   localparam logic [2:0] PAGE_ENABLE = 3'd0;
   localparam logic [2:0] PAGE_ROMSEL = 3'd1;
   localparam logic [2:0] PAGE_RAMSEL = 3'd2;
   localparam logic [2:0] PAGE_MODE   = 3'd3;
   localparam logic [2:0] PAGE_EXTRAM = 3'd5;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef enum logic [2:0] {
      RGN_ENABLE,
      RGN_ROMSEL,
      RGN_RAMSEL,
      RGN_MODE,
      RGN_EXTRAM,
      RGN_NONE
   } region_type;

   typedef struct packed {
      logic              write;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
      region_type        region;
   } item_type;

endpackage

// ----- sv/cartridge_bank_mapper.sv -----
`timescale 1ns / 1ps
// Cartridge bank mapper: MBC1/MBC3/MBC5 address translation and register file.
// A transaction accepted by the front end passes through a queue slot, then the
// result register. Throughput: one transaction per cycle while results are taken,
// set by the executor reading and updating the bank state.
// Reset (synchronous): MBC1 rules, four RAM banks, ROM bank 1, clock bytes zero.
module cartridge_bank_mapper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [cbm_pkg::ADDR_W-1:0]        req_address,
   input  logic [cbm_pkg::DATA_W-1:0]        req_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cbm_pkg::KIND_W-1:0]        rsp_kind,
   output logic [cbm_pkg::ROM_ADDR_W-1:0]    rsp_rom_address,
   output logic [cbm_pkg::RAM_ADDR_W-1:0]    rsp_ram_address,
   output logic [cbm_pkg::DATA_W-1:0]        rsp_rtc_data,
   output logic                              rsp_latch_pulse
);

   logic              queue_full;
   logic              push;
   cbm_pkg::item_type push_item;
   logic              pop;
   logic              head_valid;
   cbm_pkg::item_type head_item;

   cbm_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .queue_full     (queue_full),
      .push           (push),
      .push_item      (push_item)
   );

   cbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   cbm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_rom_address  (rsp_rom_address),
      .rsp_ram_address  (rsp_ram_address),
      .rsp_rtc_data     (rsp_rtc_data),
      .rsp_latch_pulse  (rsp_latch_pulse)
   );

endmodule

// ----- sv/cbm_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts bus transactions and classifies them by address page.
// Depends on cbm_pkg.
module cbm_front (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [cbm_pkg::ADDR_W-1:0]   req_address,
   input  logic [cbm_pkg::DATA_W-1:0]   req_write_data,
   input  logic                         queue_full,
   output logic                         push,
   output cbm_pkg::item_type            push_item
);

   cbm_pkg::region_type region;

   always_comb begin
      case (req_address[15:13])
         cbm_pkg::PAGE_ENABLE: region = cbm_pkg::RGN_ENABLE;
         cbm_pkg::PAGE_ROMSEL: region = cbm_pkg::RGN_ROMSEL;
         cbm_pkg::PAGE_RAMSEL: region = cbm_pkg::RGN_RAMSEL;
         cbm_pkg::PAGE_MODE:   region = cbm_pkg::RGN_MODE;
         cbm_pkg::PAGE_EXTRAM: region = cbm_pkg::RGN_EXTRAM;
         default:              region = cbm_pkg::RGN_NONE;
      endcase
   end

   assign req_ready         = !queue_full;
   assign push              = req_valid && !queue_full;
   assign push_item.write   = req_operation;
   assign push_item.address = req_address;
   assign push_item.data    = req_write_data;
   assign push_item.region  = region;

endmodule

// ----- sv/cbm_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of classified transactions between front end and executor.
// Depends on cbm_pkg.
module cbm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbm_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output cbm_pkg::item_type head_item
);

   cbm_pkg::item_type                  entry_ff [cbm_pkg::QUEUE_DEPTH];
   logic [cbm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cbm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cbm_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full       = (count_ff == cbm_pkg::QUEUE_CNT_W'(cbm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == cbm_pkg::QUEUE_PTR_W'(cbm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == cbm_pkg::QUEUE_PTR_W'(cbm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/cbm_back.sv -----
`timescale 1ns / 1ps
// Executor: holds bank state and configuration, carries out one queued item per
// cycle into the result register while it is free or taken. Depends on cbm_pkg.
module cbm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              head_valid,
   input  cbm_pkg::item_type                 head_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cbm_pkg::KIND_W-1:0]        rsp_kind,
   output logic [cbm_pkg::ROM_ADDR_W-1:0]    rsp_rom_address,
   output logic [cbm_pkg::RAM_ADDR_W-1:0]    rsp_ram_address,
   output logic [cbm_pkg::DATA_W-1:0]        rsp_rtc_data,
   output logic                              rsp_latch_pulse
);

   // Configuration
   logic [cbm_pkg::MAPPER_W-1:0]   mapper_ff;
   logic [cbm_pkg::BANKS_W-1:0]    ram_banks_ff;

   // Controller state
   logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   logic                           ram_enabled_ff, ram_enabled_in;
   logic                           bank_mode_ff, bank_mode_in;
   logic                           zero_seen_ff, zero_seen_in;
   logic [cbm_pkg::DATA_W-1:0]     clock_ff [cbm_pkg::RTC_COUNT];
   logic                           clock_we;

   // Result register
   logic                           rsp_valid_ff;
   logic [cbm_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [cbm_pkg::ROM_ADDR_W-1:0] rom_addr_ff, rom_addr_in;
   logic [cbm_pkg::RAM_ADDR_W-1:0] ram_addr_ff, ram_addr_in;
   logic [cbm_pkg::DATA_W-1:0]     rtc_data_ff, rtc_data_in;
   logic                           latch_ff, latch_in;

   logic [cbm_pkg::RAM_BANK_W-1:0] rtc_off;
   logic [cbm_pkg::RTC_IDX_W-1:0]  rtc_idx;
   logic                           is_rtc;
   logic                           bank_missing;
   logic [cbm_pkg::RAM_BANK_W-1:0] banks_wide;
   logic [cbm_pkg::RAM_BANK_W-1:0] mbc1_ram_bank;
   logic [4:0]                     low5;
   logic [6:0]                     low7;
   logic [cbm_pkg::DATA_W-1:0]     v;

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   assign v            = head_item.data;
   assign banks_wide   = {3'b000, ram_banks_ff};
   assign rtc_off      = ram_bank_ff - cbm_pkg::RTC_BASE;
   assign rtc_idx      = rtc_off[cbm_pkg::RTC_IDX_W-1:0];
   assign is_rtc       = (mapper_ff == cbm_pkg::MAPPER_MBC3) &&
                         (ram_bank_ff >= cbm_pkg::RTC_BASE) &&
                         (rtc_off < cbm_pkg::RAM_BANK_W'(cbm_pkg::RTC_COUNT));
   assign bank_missing = (ram_bank_ff >= banks_wide);
   assign low5         = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
   assign low7         = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];

   // MBC1 RAM bank select with clamp to the last present bank
   always_comb begin
      mbc1_ram_bank = {6'b000000, v[1:0]};
      if (mbc1_ram_bank >= banks_wide) begin
         mbc1_ram_bank = (ram_banks_ff == '0) ? '0 : banks_wide - 1'b1;
      end
   end

   always_comb begin
      rom_bank_in    = rom_bank_ff;
      ram_bank_in    = ram_bank_ff;
      ram_enabled_in = ram_enabled_ff;
      bank_mode_in   = bank_mode_ff;
      zero_seen_in   = zero_seen_ff;
      clock_we       = 1'b0;
      kind_in        = cbm_pkg::KIND_REG_WR;
      rom_addr_in    = '0;
      ram_addr_in    = '0;
      rtc_data_in    = '0;
      latch_in       = 1'b0;

      if (mapper_ff == cbm_pkg::MAPPER_UNUSED) begin
         kind_in = cbm_pkg::KIND_ERROR;
      end else if (!head_item.write) begin
         case (head_item.region)
            cbm_pkg::RGN_ENABLE, cbm_pkg::RGN_ROMSEL: begin
               kind_in     = cbm_pkg::KIND_ROM_RD;
               rom_addr_in = {7'd0, head_item.address};
            end
            cbm_pkg::RGN_RAMSEL, cbm_pkg::RGN_MODE: begin
               kind_in = cbm_pkg::KIND_ROM_RD;
               if (mapper_ff == cbm_pkg::MAPPER_MBC5) begin
                  rom_addr_in = {rom_bank_ff, head_item.address[13:0]};
               end else begin
                  rom_addr_in = {2'b00, rom_bank_ff[6:0], head_item.address[13:0]};
               end
            end
            cbm_pkg::RGN_EXTRAM: begin
               if (is_rtc) begin
                  kind_in     = cbm_pkg::KIND_RTC_RD;
                  rtc_data_in = clock_ff[rtc_idx];
               end else if (bank_missing) begin
                  kind_in = cbm_pkg::KIND_ERROR;
               end else begin
                  kind_in     = cbm_pkg::KIND_RAM_RD;
                  ram_addr_in = {ram_bank_ff[3:0], head_item.address[12:0]};
               end
            end
            default: kind_in = cbm_pkg::KIND_ERROR;
         endcase
      end else begin
         case (head_item.region)
            cbm_pkg::RGN_ENABLE: ram_enabled_in = (v[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            cbm_pkg::RGN_ROMSEL: begin
               if (mapper_ff == cbm_pkg::MAPPER_MBC1) begin
                  rom_bank_in = {2'b00, rom_bank_ff[6:5], low5};
               end else if (mapper_ff == cbm_pkg::MAPPER_MBC3) begin
                  rom_bank_in = {2'b00, low7};
               end else if (!head_item.address[12]) begin
                  rom_bank_in = {rom_bank_ff[8], v};
               end else begin
                  rom_bank_in = {v[0], rom_bank_ff[7:0]};
               end
            end
            cbm_pkg::RGN_RAMSEL: begin
               if (mapper_ff == cbm_pkg::MAPPER_MBC1) begin
                  if (bank_mode_ff) begin
                     ram_bank_in = mbc1_ram_bank;
                  end else begin
                     rom_bank_in = {2'b00, v[1:0], rom_bank_ff[4:0]};
                  end
               end else if (mapper_ff == cbm_pkg::MAPPER_MBC3) begin
                  ram_bank_in = v;
               end else begin
                  ram_bank_in = {4'd0, v[3:0]};
               end
            end
            cbm_pkg::RGN_MODE: begin
               if (mapper_ff == cbm_pkg::MAPPER_MBC1) begin
                  bank_mode_in = v[0];
               end else if (mapper_ff == cbm_pkg::MAPPER_MBC3) begin
                  // latch fires on a zero write followed directly by a one
                  if (v == 8'd0) begin
                     zero_seen_in = 1'b1;
                  end else begin
                     zero_seen_in = 1'b0;
                     latch_in     = zero_seen_ff && (v == 8'd1);
                  end
               end
            end
            cbm_pkg::RGN_EXTRAM: begin
               if ((mapper_ff != cbm_pkg::MAPPER_MBC3) || (ram_bank_ff <= 8'd3)) begin
                  if (bank_missing) begin
                     kind_in = cbm_pkg::KIND_ERROR;
                  end else if (ram_enabled_ff) begin
                     kind_in     = cbm_pkg::KIND_RAM_WR;
                     ram_addr_in = {ram_bank_ff[3:0], head_item.address[12:0]};
                  end
               end else if (is_rtc) begin
                  clock_we = 1'b1;
               end else begin
                  kind_in = cbm_pkg::KIND_ERROR;
               end
            end
            default: kind_in = cbm_pkg::KIND_ERROR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_ff      <= cbm_pkg::MAPPER_MBC1;
         ram_banks_ff   <= 5'd4;
         rom_bank_ff    <= 9'd1;
         ram_bank_ff    <= '0;
         ram_enabled_ff <= 1'b0;
         bank_mode_ff   <= 1'b0;
         zero_seen_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < cbm_pkg::RTC_COUNT; i++) begin
            clock_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               cbm_pkg::CSR_MAPPER_KIND: mapper_ff    <= csr_write_data[1:0];
               cbm_pkg::CSR_RAM_BANKS:   ram_banks_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (pop) begin
            rom_bank_ff    <= rom_bank_in;
            ram_bank_ff    <= ram_bank_in;
            ram_enabled_ff <= ram_enabled_in;
            bank_mode_ff   <= bank_mode_in;
            zero_seen_ff   <= zero_seen_in;
            if (clock_we) begin
               clock_ff[rtc_idx] <= v;
            end
         end
         rsp_valid_ff <= pop || (rsp_valid_ff && !rsp_ready);
      end
   end

   // Result payload: load on pop, hold while stalled
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff     <= kind_in;
         rom_addr_ff <= rom_addr_in;
         ram_addr_ff <= ram_addr_in;
         rtc_data_ff <= rtc_data_in;
         latch_ff    <= latch_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_rom_address = rom_addr_ff;
   assign rsp_ram_address = ram_addr_ff;
   assign rsp_rtc_data    = rtc_data_ff;
   assign rsp_latch_pulse = latch_ff;

endmodule

// ----- tb/sv/cartridge_bank_mapper_test.sv -----
`timescale 1ns / 1ps
// Self-checking test of cartridge_bank_mapper: directed and random accesses per controller kind.
// Expected results come from a local copy of the bank state; uses cbm_pkg for widths and codes.
module cartridge_bank_mapper_test;

   typedef struct packed {
      logic                       write;
      logic [cbm_pkg::ADDR_W-1:0] address;
      logic [cbm_pkg::DATA_W-1:0] data;
   } bus_access_type;

   typedef struct packed {
      logic [cbm_pkg::KIND_W-1:0]     kind;
      logic [cbm_pkg::ROM_ADDR_W-1:0] rom_address;
      logic [cbm_pkg::RAM_ADDR_W-1:0] ram_address;
      logic [cbm_pkg::DATA_W-1:0]     rtc_data;
      logic                           latch_pulse;
   } bus_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [cbm_pkg::CSR_IDX_W-1:0]  csr_index = cbm_pkg::CSR_MAPPER_KIND;
   logic [cbm_pkg::CSR_DATA_W-1:0] csr_write_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_operation = 1'b0;
   logic [cbm_pkg::ADDR_W-1:0]     req_address = '0;
   logic [cbm_pkg::DATA_W-1:0]     req_write_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [cbm_pkg::KIND_W-1:0]     rsp_kind;
   logic [cbm_pkg::ROM_ADDR_W-1:0] rsp_rom_address;
   logic [cbm_pkg::RAM_ADDR_W-1:0] rsp_ram_address;
   logic [cbm_pkg::DATA_W-1:0]     rsp_rtc_data;
   logic                           rsp_latch_pulse;

   // Mirror of the controller state
   logic [cbm_pkg::MAPPER_W-1:0]   sel_mapper = cbm_pkg::MAPPER_MBC1;
   logic [cbm_pkg::BANKS_W-1:0]    sel_ram_banks = 5'd4;
   logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank = 9'd1;
   logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank = '0;
   logic                           ram_on = 1'b0;
   logic                           banking_mode = 1'b0;
   logic                           latch_armed = 1'b0;
   logic [cbm_pkg::DATA_W-1:0]     clock_regs [cbm_pkg::RTC_COUNT] = '{default: '0};

   bus_access_type access_queue [$];
   bus_result_type expected_translations [$];
   bit             access_on_bus = 1'b0;
   bit             steady = 1'b0;
   int unsigned    send_gap = 0;
   int unsigned    recv_stall = 0;
   int unsigned    error_count = 0;

   cartridge_bank_mapper u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_rom_address  (rsp_rom_address),
      .rsp_ram_address  (rsp_ram_address),
      .rsp_rtc_data     (rsp_rtc_data),
      .rsp_latch_pulse  (rsp_latch_pulse)
   );

   always #5 clock = ~clock;

   // Work out the result of one access and advance the mirrored bank state.
   function automatic bus_result_type translate_access(bus_access_type acc);
      bus_result_type                 res;
      logic [2:0]                     page;
      logic [4:0]                     low;
      logic [6:0]                     sel7;
      logic [cbm_pkg::ROM_BANK_W-1:0] bank;
      logic [cbm_pkg::RAM_ADDR_W-1:0] ram_addr;
      logic [cbm_pkg::RAM_BANK_W-1:0] present;
      logic [cbm_pkg::RAM_BANK_W-1:0] clock_off;
      logic [cbm_pkg::RTC_IDX_W-1:0]  clock_idx;
      bit                             on_clock;
      res = '0;
      res.kind = cbm_pkg::KIND_REG_WR;
      page = acc.address[15:13];
      ram_addr = {ram_bank[3:0], acc.address[12:0]};
      present = {3'b000, sel_ram_banks};
      clock_off = ram_bank - cbm_pkg::RTC_BASE;
      clock_idx = clock_off[cbm_pkg::RTC_IDX_W-1:0];
      on_clock = sel_mapper == cbm_pkg::MAPPER_MBC3 && ram_bank >= cbm_pkg::RTC_BASE
                 && clock_off < cbm_pkg::RAM_BANK_W'(cbm_pkg::RTC_COUNT);
      if (sel_mapper == cbm_pkg::MAPPER_UNUSED) begin
         res.kind = cbm_pkg::KIND_ERROR;
         return res;
      end
      if (!acc.write) begin
         if (acc.address[15:14] == 2'b00) begin
            res.kind = cbm_pkg::KIND_ROM_RD;
            res.rom_address = cbm_pkg::ROM_ADDR_W'(acc.address);
         end else if (!acc.address[15]) begin
            bank = (sel_mapper == cbm_pkg::MAPPER_MBC5) ? rom_bank : {2'b00, rom_bank[6:0]};
            res.kind = cbm_pkg::KIND_ROM_RD;
            res.rom_address = {bank, acc.address[13:0]};
         end else if (page == cbm_pkg::PAGE_EXTRAM) begin
            if (on_clock) begin
               res.kind = cbm_pkg::KIND_RTC_RD;
               res.rtc_data = clock_regs[clock_idx];
            end else if (ram_bank >= present) begin
               res.kind = cbm_pkg::KIND_ERROR;
            end else begin
               res.kind = cbm_pkg::KIND_RAM_RD;
               res.ram_address = ram_addr;
            end
         end else begin
            res.kind = cbm_pkg::KIND_ERROR;
         end
         return res;
      end
      case (page)
         cbm_pkg::PAGE_ENABLE: ram_on = acc.data[3:0] == cbm_pkg::RAM_ENABLE_KEY;
         cbm_pkg::PAGE_ROMSEL: begin
            if (sel_mapper == cbm_pkg::MAPPER_MBC1) begin
               low = acc.data[4:0];
               if (low == 5'd0) low = 5'd1;
               rom_bank = {2'b00, rom_bank[6:5], low};
            end else if (sel_mapper == cbm_pkg::MAPPER_MBC3) begin
               sel7 = acc.data[6:0];
               if (sel7 == 7'd0) sel7 = 7'd1;
               rom_bank = {2'b00, sel7};
            end else if (!acc.address[12]) begin
               rom_bank = {rom_bank[8], acc.data};
            end else begin
               rom_bank = {acc.data[0], rom_bank[7:0]};
            end
         end
         cbm_pkg::PAGE_RAMSEL: begin
            if (sel_mapper == cbm_pkg::MAPPER_MBC1) begin
               if (banking_mode) begin
                  ram_bank = {6'd0, acc.data[1:0]};
                  // clamp to the last bank present
                  if (ram_bank >= present)
                     ram_bank = (sel_ram_banks == '0) ? '0 : present - 1'b1;
               end else begin
                  rom_bank = {2'b00, acc.data[1:0], rom_bank[4:0]};
               end
            end else if (sel_mapper == cbm_pkg::MAPPER_MBC3) begin
               ram_bank = acc.data;
            end else begin
               ram_bank = {4'd0, acc.data[3:0]};
            end
         end
         cbm_pkg::PAGE_MODE: begin
            if (sel_mapper == cbm_pkg::MAPPER_MBC1) begin
               banking_mode = acc.data[0];
            end else if (sel_mapper == cbm_pkg::MAPPER_MBC3) begin
               if (acc.data == 8'd0) begin
                  latch_armed = 1'b1;
               end else if (latch_armed && acc.data == 8'd1) begin
                  latch_armed = 1'b0;
                  res.latch_pulse = 1'b1;
               end else begin
                  latch_armed = 1'b0;
               end
            end
         end
         cbm_pkg::PAGE_EXTRAM: begin
            if (sel_mapper != cbm_pkg::MAPPER_MBC3 || ram_bank <= 8'd3) begin
               if (ram_bank >= present) begin
                  res.kind = cbm_pkg::KIND_ERROR;
               end else if (ram_on) begin
                  res.kind = cbm_pkg::KIND_RAM_WR;
                  res.ram_address = ram_addr;
               end
            end else if (on_clock) begin
               clock_regs[clock_idx] = acc.data;
            end else begin
               res.kind = cbm_pkg::KIND_ERROR;
            end
         end
         default: res.kind = cbm_pkg::KIND_ERROR;
      endcase
      return res;
   endfunction

   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(25, 6);
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   // Request driver: present queued accesses, predict each one as it is taken.
   always @(posedge clock) begin : request_driver
      bus_access_type taken;
      bus_access_type nxt;
      logic           drive;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive = req_valid;
         if (req_valid && req_ready) begin
            taken.write = req_operation;
            taken.address = req_address;
            taken.data = req_write_data;
            expected_translations.push_back(translate_access(taken));
            drive = 1'b0;
            access_on_bus = 1'b0;
            send_gap = steady ? 0 : idle_span();
         end
         if (!drive) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (access_queue.size() > 0) begin
               nxt = access_queue.pop_front();
               req_operation <= nxt.write;
               req_address <= nxt.address;
               req_write_data <= nxt.data;
               drive = 1'b1;
               access_on_bus = 1'b1;
            end
         end
         req_valid <= drive;
      end
   end

   // Result monitor: compare each transaction with the oldest prediction.
   always @(posedge clock) begin : result_monitor
      bus_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_translations.size() == 0) begin
               $error("unexpected result: kind 0x%0h", rsp_kind);
               error_count++;
            end else begin
               want = expected_translations.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("rom_address", 32'(want.rom_address), 32'(rsp_rom_address));
               check_field("ram_address", 32'(want.ram_address), 32'(rsp_ram_address));
               check_field("rtc_data", 32'(want.rtc_data), 32'(rsp_rtc_data));
               check_field("latch_pulse", 32'(want.latch_pulse), 32'(rsp_latch_pulse));
            end
            recv_stall = steady ? 0 : idle_span();
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void queue_access(bit wr, logic [cbm_pkg::ADDR_W-1:0] addr,
                                        logic [cbm_pkg::DATA_W-1:0] data);
      bus_access_type acc;
      acc.write = wr;
      acc.address = addr;
      acc.data = data;
      access_queue.push_back(acc);
   endfunction

   function automatic logic [cbm_pkg::ADDR_W-1:0] in_page(logic [2:0] page);
      return {page, 13'($urandom)};
   endfunction

   // Bank numbers weighted towards RAM banks and the clock registers.
   function automatic logic [cbm_pkg::DATA_W-1:0] bank_byte();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 4) return 8'($urandom_range(3));
      if (roll < 6) return 8'($urandom_range(12, 8));
      if (roll < 8) return 8'($urandom_range(15));
      return 8'($urandom);
   endfunction

   task automatic queue_random_accesses(int unsigned count);
      int unsigned made;
      int unsigned pick;
      logic [2:0]  page;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // latch sequence, sometimes broken on the second write
            queue_access(1'b1, in_page(cbm_pkg::PAGE_MODE), 8'h00);
            queue_access(1'b1, in_page(cbm_pkg::PAGE_MODE),
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'h01);
            made += 2;
         end else if (pick < 25) begin
            queue_access(1'b1, in_page(cbm_pkg::PAGE_RAMSEL), bank_byte());
            queue_access(1'($urandom_range(1)), in_page(cbm_pkg::PAGE_EXTRAM),
                         8'($urandom));
            queue_access(1'($urandom_range(1)), in_page(cbm_pkg::PAGE_EXTRAM),
                         8'($urandom));
            made += 3;
         end else begin
            if (pick < 35)
               queue_access(1'b1, in_page(cbm_pkg::PAGE_ENABLE),
                            $urandom_range(1) ? {4'($urandom), cbm_pkg::RAM_ENABLE_KEY}
                                              : 8'($urandom));
            else if (pick < 46)
               queue_access(1'b1, in_page(cbm_pkg::PAGE_ROMSEL), 8'($urandom));
            else if (pick < 53)
               queue_access(1'b1, in_page(cbm_pkg::PAGE_RAMSEL), bank_byte());
            else if (pick < 60)
               queue_access(1'b1, in_page(cbm_pkg::PAGE_MODE),
                            $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom));
            else if (pick < 76)
               queue_access(1'b0, {1'b0, 15'($urandom)}, 8'($urandom));
            else if (pick < 86)
               queue_access(1'($urandom_range(1)), in_page(cbm_pkg::PAGE_EXTRAM),
                            8'($urandom));
            else if (pick < 92) begin
               // unmapped pages: 0x8000 and 0xC000 upwards
               page = 3'($urandom_range(2));
               page = (page == 3'd0) ? 3'd4 : page + 3'd5;
               queue_access(1'($urandom_range(1)), in_page(page), 8'($urandom));
            end else
               queue_access(1'($urandom_range(1)), 16'($urandom), 8'($urandom));
            made++;
         end
      end
   endtask

   task automatic wait_idle();
      while (access_queue.size() != 0 || access_on_bus || expected_translations.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(logic [cbm_pkg::MAPPER_W-1:0] kind,
                            logic [cbm_pkg::BANKS_W-1:0] banks, bit calm);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= cbm_pkg::CSR_MAPPER_KIND;
      csr_write_data <= cbm_pkg::CSR_DATA_W'(kind);
      @(posedge clock);
      csr_index <= cbm_pkg::CSR_RAM_BANKS;
      csr_write_data <= banks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sel_mapper = kind;
      sel_ram_banks = banks;
      steady = calm;
   endtask

   initial begin : stimulus
      logic [cbm_pkg::MAPPER_W-1:0] kinds [11];
      logic [cbm_pkg::BANKS_W-1:0]  banks [11];
      kinds = '{cbm_pkg::MAPPER_MBC3, cbm_pkg::MAPPER_MBC1, cbm_pkg::MAPPER_MBC5,
                cbm_pkg::MAPPER_MBC1, cbm_pkg::MAPPER_MBC3, cbm_pkg::MAPPER_MBC5,
                cbm_pkg::MAPPER_MBC1, cbm_pkg::MAPPER_MBC3, cbm_pkg::MAPPER_MBC5,
                cbm_pkg::MAPPER_MBC1, cbm_pkg::MAPPER_MBC3};
      banks = '{5'd16, 5'd0, 5'd0, 5'd16, 5'd1, 5'd16, 5'd2, 5'd0, 5'd5, 5'd4, 5'd13};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // MBC1 after reset, four RAM banks
      queue_access(1'b0, 16'h0000, 8'hFF);
      queue_access(1'b0, 16'h7FFF, 8'h00);
      queue_access(1'b0, 16'h8000, 8'h00);
      queue_access(1'b1, 16'hFFFF, 8'hFF);
      queue_access(1'b1, 16'hA123, 8'h55);   // RAM still disabled
      queue_access(1'b1, 16'h2000, 8'h00);   // zero selects bank 1
      queue_access(1'b1, 16'h4000, 8'h03);
      queue_access(1'b0, 16'h4000, 8'h00);
      queue_access(1'b1, 16'h0000, 8'h0A);
      queue_access(1'b1, 16'hBFFF, 8'hFF);
      queue_access(1'b1, 16'h6000, 8'h01);
      queue_access(1'b1, 16'h5FFF, 8'hFF);
      queue_access(1'b0, 16'hBFFF, 8'h00);

      configure(cbm_pkg::MAPPER_MBC3, 5'd16, 1'b0);
      queue_access(1'b1, 16'h4000, 8'h08);
      queue_access(1'b1, 16'hA000, 8'h5A);
      queue_access(1'b0, 16'hA000, 8'h00);
      queue_access(1'b1, 16'h4000, 8'h0D);   // beyond the clock registers
      queue_access(1'b0, 16'hA000, 8'h00);
      queue_access(1'b1, 16'h4000, 8'h05);
      queue_access(1'b0, 16'hB000, 8'h00);
      queue_access(1'b1, 16'hB000, 8'h12);
      queue_access(1'b1, 16'h6000, 8'h00);
      queue_access(1'b1, 16'h7FFF, 8'h01);

      configure(cbm_pkg::MAPPER_MBC5, 5'd0, 1'b0);
      queue_access(1'b1, 16'h2000, 8'hFF);
      queue_access(1'b1, 16'h3000, 8'h01);
      queue_access(1'b0, 16'h7FFF, 8'h00);
      queue_access(1'b1, 16'h6000, 8'h01);
      queue_access(1'b1, 16'h2FFF, 8'h00);   // low byte zero, ninth bit still set: bank 0x100
      queue_access(1'b0, 16'h4000, 8'h00);
      queue_access(1'b0, 16'hA000, 8'h00);

      configure(cbm_pkg::MAPPER_UNUSED, 5'd4, 1'b0);
      queue_random_accesses(4);

      for (int p = 0; p < 11; p++) begin
         configure(kinds[p], banks[p], p % 4 == 3);
         queue_random_accesses(36);
      end

      wait_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
